// ===== rtl/lge_pkg.sv =====
`default_nettype none

package lge_pkg;

    // Operation codes carried on s_tuser.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2
    } lge_op_t;

    // Field widths of the input and result transactions.
    localparam int OP_W        = 2;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 6;
    localparam int S_TDATA_W   = 16;
    localparam int POP_W       = 10;
    localparam int GEN_W       = 16;
    localparam int M_TDATA_W   = 32;
    localparam int OUT_PAD_W   = M_TDATA_W - 1 - POP_W - GEN_W;

    // Rule B3/S23: a dead cell is born on three neighbors, a live cell survives on two or three.
    localparam int NBR_W          = 4;
    localparam int BIRTH_COUNT    = 3;
    localparam int SURVIVE_COUNT  = 2;

endpackage

`default_nettype wire

// ===== rtl/lge_row_ram.sv =====
`default_nettype none

module lge_row_ram #(
    parameter int  DEPTH = 21,
    parameter int  WIDTH = 40,
    localparam int AW    = $clog2(DEPTH)
)(
    input  wire              clk,
    input  wire              wr_en,
    input  wire  [AW-1:0]    wr_addr,
    input  wire  [WIDTH-1:0] wr_data,
    input  wire              rd_en,
    input  wire  [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    // One grid row per entry.
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lge_rule.sv =====
`default_nettype none

module lge_rule
    import lge_pkg::*;
#(
    parameter int COLS = 40
)(
    input  wire  [COLS-1:0] up_row,
    input  wire  [COLS-1:0] cur_row,
    input  wire  [COLS-1:0] dn_row,
    output logic [COLS-1:0] nxt_row
);

    // Each cell counts its eight neighbors, with the columns wrapping around.
    for (genvar c = 0; c < COLS; c++)
    begin : g_cell
        localparam int LF = (c == 0) ? COLS - 1 : c - 1;
        localparam int RT = (c == COLS - 1) ? 0 : c + 1;

        logic [NBR_W-1:0] nbr;

        assign nbr = NBR_W'(up_row[LF]) + NBR_W'(up_row[c]) + NBR_W'(up_row[RT])
                   + NBR_W'(cur_row[LF]) + NBR_W'(cur_row[RT])
                   + NBR_W'(dn_row[LF]) + NBR_W'(dn_row[c]) + NBR_W'(dn_row[RT]);

        assign nxt_row[c] = (nbr == NBR_W'(BIRTH_COUNT))
                         || ((nbr == NBR_W'(SURVIVE_COUNT)) && cur_row[c]);
    end

endmodule

`default_nettype wire

// ===== rtl/life_grid_generation_engine.sv =====
// A write or a read inside the grid passes through S_CELL and S_EMIT before its result is registered;
// an unused code or an out-of-range access goes straight to S_EMIT, which waits while a result is not yet taken.
// A generation, for each row in turn, computes and writes back the new row, then counts
// the live cells of that new row serially.
// One transaction is in work at a time; the next is accepted while the result still waits.
// Reset is asynchronous; after it a clearing pass writes every row dead, during which s_tready stays low.
`default_nettype none

module life_grid_generation_engine
    import lge_pkg::*;
#(
    parameter int GRID_ROWS = 21,
    parameter int GRID_COLS = 40
)(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [S_TDATA_W-1:0]  s_tdata,   // row[4:0], col[10:5], alive[11], zeros[15:12]
    input  wire  [OP_W-1:0]       s_tuser,   // op[1:0]
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // cell_value[0], population[10:1], generation[26:11]
);

    localparam int ROW_AW = $clog2(GRID_ROWS);
    localparam int COL_AW = $clog2(GRID_COLS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL,
        S_G_LD0,
        S_G_LD1,
        S_G_LD2,
        S_G_ROW,
        S_G_CNT,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [ROW_AW-1:0]      r_reg;
    logic [COL_AW-1:0]      bit_reg;
    logic [POP_W-1:0]       acc_reg;
    logic [POP_W-1:0]       pop_reg;
    logic [GEN_W-1:0]       gen_reg;
    logic                   cell_reg;
    logic                   is_write_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    logic [ROW_AW-1:0]      row_reg;
    logic [COL_AW-1:0]      col_reg;
    logic                   alive_reg;
    logic [GRID_COLS-1:0]   up_reg;
    logic [GRID_COLS-1:0]   cur_reg;
    logic [GRID_COLS-1:0]   dn_reg;
    logic [GRID_COLS-1:0]   first_reg;
    logic [GRID_COLS-1:0]   shift_reg;

    logic                   accept;
    lge_op_t                op_in;
    logic [ROW_FIELD_W-1:0] row_in;
    logic [COL_FIELD_W-1:0] col_in;
    logic                   alive_in;
    logic                   in_grid;
    logic                   old_bit;
    logic                   last_col;
    logic                   last_row;

    logic                   wr_en;
    logic [ROW_AW-1:0]      wr_addr;
    logic [GRID_COLS-1:0]   wr_data;
    logic                   rd_en;
    logic [ROW_AW-1:0]      rd_addr;
    logic [GRID_COLS-1:0]   rd_data;
    logic [GRID_COLS-1:0]   nxt_row;
    logic [GRID_COLS-1:0]   modified_row;

    // Input fields and the range check for cell accesses.
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign op_in    = lge_op_t'(s_tuser);
    assign row_in   = s_tdata[ROW_FIELD_W-1:0];
    assign col_in   = s_tdata[ROW_FIELD_W +: COL_FIELD_W];
    assign alive_in = s_tdata[ROW_FIELD_W + COL_FIELD_W];
    assign in_grid  = (int'(row_in) < GRID_ROWS) && (int'(col_in) < GRID_COLS);

    assign old_bit  = rd_data[col_reg];
    assign last_col = (bit_reg == COL_AW'(GRID_COLS - 1));
    assign last_row = (r_reg == ROW_AW'(GRID_ROWS - 1));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The addressed row with the one cell replaced, for a cell write.
    always_comb
    begin
        modified_row          = rd_data;
        modified_row[col_reg] = alive_reg;
    end

    lge_row_ram #(
        .DEPTH (GRID_ROWS),
        .WIDTH (GRID_COLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lge_rule #(
        .COLS (GRID_COLS)
    ) u_rule (
        .up_row  (up_reg),
        .cur_row (cur_reg),
        .dn_row  (dn_reg),
        .nxt_row (nxt_row)
    );

    // Memory accesses for each state.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = r_reg;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = r_reg;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op_in == OP_STEP)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ROW_AW'(GRID_ROWS - 1);
                    end
                    else if (((op_in == OP_WRITE) || (op_in == OP_READ)) && in_grid)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ROW_AW'(row_in);
                    end
                end
            end
            S_CELL:
            begin
                wr_en   = is_write_reg;
                wr_addr = row_reg;
                wr_data = modified_row;
            end
            S_G_LD0:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_G_LD1:
            begin
                rd_en   = 1'b1;
                rd_addr = ROW_AW'(1);
            end
            S_G_ROW:
            begin
                // The new row overwrites row r; row r + 2 is still the old generation.
                wr_en   = 1'b1;
                wr_data = nxt_row;
                if (int'(r_reg) < GRID_ROWS - 2)
                begin
                    rd_en   = 1'b1;
                    rd_addr = r_reg + ROW_AW'(2);
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer, counters and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            r_reg        <= '0;
            bit_reg      <= '0;
            acc_reg      <= '0;
            pop_reg      <= '0;
            gen_reg      <= '0;
            cell_reg     <= 1'b0;
            is_write_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            // In S_EMIT the result register is reloaded instead.
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (last_row)
                    begin
                        r_reg     <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        r_reg <= r_reg + ROW_AW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cell_reg <= 1'b0;
                        case (op_in)
                            OP_STEP:
                            begin
                                acc_reg   <= '0;
                                r_reg     <= '0;
                                state_reg <= S_G_LD0;
                            end
                            OP_WRITE, OP_READ:
                            begin
                                is_write_reg <= (op_in == OP_WRITE);
                                state_reg    <= in_grid ? S_CELL : S_EMIT;
                            end
                            default:
                            begin
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_CELL:
                begin
                    if (is_write_reg)
                    begin
                        if (old_bit && !alive_reg)
                        begin
                            pop_reg <= pop_reg - POP_W'(1);
                        end
                        else if (!old_bit && alive_reg)
                        begin
                            pop_reg <= pop_reg + POP_W'(1);
                        end
                    end
                    else
                    begin
                        cell_reg <= old_bit;
                    end
                    state_reg <= S_EMIT;
                end
                S_G_LD0:
                begin
                    state_reg <= S_G_LD1;
                end
                S_G_LD1:
                begin
                    state_reg <= S_G_LD2;
                end
                S_G_LD2:
                begin
                    state_reg <= S_G_ROW;
                end
                S_G_ROW:
                begin
                    bit_reg   <= '0;
                    state_reg <= S_G_CNT;
                end
                S_G_CNT:
                begin
                    // Count the live cells of the new row one column per cycle.
                    acc_reg <= acc_reg + POP_W'(shift_reg[0]);
                    if (last_col)
                    begin
                        bit_reg <= '0;
                        if (last_row)
                        begin
                            pop_reg   <= acc_reg + POP_W'(shift_reg[0]);
                            gen_reg   <= gen_reg + GEN_W'(1);
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            r_reg     <= r_reg + ROW_AW'(1);
                            state_reg <= S_G_ROW;
                        end
                    end
                    else
                    begin
                        bit_reg <= bit_reg + COL_AW'(1);
                    end
                end
                S_EMIT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{OUT_PAD_W{1'b0}}, gen_reg, pop_reg, cell_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Row window and cell operands; payload only.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    row_reg   <= ROW_AW'(row_in);
                    col_reg   <= COL_AW'(col_in);
                    alive_reg <= alive_in;
                end
            end
            S_G_LD0:
            begin
                up_reg <= rd_data;
            end
            S_G_LD1:
            begin
                cur_reg   <= rd_data;
                first_reg <= rd_data;
            end
            S_G_LD2:
            begin
                dn_reg <= rd_data;
            end
            S_G_ROW:
            begin
                up_reg    <= cur_reg;
                cur_reg   <= dn_reg;
                shift_reg <= nxt_row;
            end
            S_G_CNT:
            begin
                shift_reg <= shift_reg >> 1;
                // The row below the next one; row 0 comes from the saved copy of the old one.
                if (last_col)
                begin
                    dn_reg <= (int'(r_reg) == GRID_ROWS - 2) ? first_reg : rd_data;
                end
            end
            default:
            begin
                shift_reg <= shift_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The generation count moves only when the last row of a generation is counted.
    a_gen_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (gen_reg != $past(gen_reg)) |-> ($past(state_reg) == S_G_CNT))
        else $error("generation count changed outside the end of a generation");

    // The row counter stays inside the grid while a generation runs.
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_G_ROW) || (state_reg == S_G_CNT)) |-> (int'(r_reg) < GRID_ROWS))
        else $error("row counter left the grid");

    // The population never exceeds the number of cells when it fits the field.
    a_pop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (GRID_ROWS * GRID_COLS > 1023) || (int'(pop_reg) <= GRID_ROWS * GRID_COLS))
        else $error("population exceeds the grid size");

    // An accepted transaction always starts work.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not leave idle");

    // No result is offered before the clearing pass is done.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !m_tvalid_reg)
        else $error("result offered during the clearing pass");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_life_grid_generation_engine.sv =====
`timescale 1ns / 100ps

module tb_life_grid_generation_engine;

    import lge_pkg::*;

    localparam int ROWS        = 21;
    localparam int COLS        = 40;
    localparam int ITEM_TARGET = 710;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DIR_ROWS    = 25;

    // The block decodes op 3 as a no-op; the package has no name for it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic             cell_bit;
        logic [POP_W-1:0] pop;
        logic [GEN_W-1:0] gen;
    } life_result_t;

    // One row of the directed table; res is used only where fixed is set.
    typedef struct packed {
        logic [1:0]   op;
        logic [4:0]   row;
        logic [5:0]   col;
        logic         alive;
        logic         fixed;
        life_result_t res;
    } dir_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // row[4:0], col[10:5], alive[11], zeros[15:12]
    logic [OP_W-1:0]      s_tuser;    // op[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // cell_value[0], population[10:1], generation[26:11]

    // Shadow copy of the grid and its counters.
    bit                   shadow_cells [ROWS][COLS];
    int unsigned          shadow_live;
    logic [GEN_W-1:0]     shadow_gen;

    life_result_t         results_due[$];
    int unsigned          mismatches;
    int unsigned          items_sent;
    int unsigned          cycles;
    bit                   quiet_in;
    bit                   quiet_out;

    dir_item_t            dir_table [0:DIR_ROWS-1];

    life_grid_generation_engine #(
        .GRID_ROWS (ROWS),
        .GRID_COLS (COLS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Applies one transaction to the shadow grid and returns the result it should give.
    function automatic life_result_t life_predict(input logic [1:0] op, input logic [4:0] row,
                                                  input logic [5:0] col, input logic alive);
        life_result_t res;
        bit           nxt [ROWS][COLS];
        int           up;
        int           dn;
        int           lf;
        int           rt;
        int           nbrs;
        int unsigned  total;
        bit           in_grid;

        in_grid      = (row < ROWS) && (col < COLS);
        res.cell_bit = 1'b0;
        if (op == OP_WRITE)
        begin
            if (in_grid)
            begin
                if (shadow_cells[row][col] && !alive)
                    shadow_live--;
                if (!shadow_cells[row][col] && alive)
                    shadow_live++;
                shadow_cells[row][col] = alive;
            end
        end
        else if (op == OP_READ)
        begin
            if (in_grid)
                res.cell_bit = shadow_cells[row][col];
        end
        else if (op == OP_STEP)
        begin
            // Birth on three neighbors, survival on two or three, edges wrapping.
            total = 0;
            for (int r = 0; r < ROWS; r++)
            begin
                up = (r + ROWS - 1) % ROWS;
                dn = (r + 1) % ROWS;
                for (int c = 0; c < COLS; c++)
                begin
                    lf   = (c + COLS - 1) % COLS;
                    rt   = (c + 1) % COLS;
                    nbrs = shadow_cells[up][lf] + shadow_cells[up][c] + shadow_cells[up][rt]
                         + shadow_cells[r][lf] + shadow_cells[r][rt]
                         + shadow_cells[dn][lf] + shadow_cells[dn][c] + shadow_cells[dn][rt];
                    nxt[r][c] = (nbrs == 3) || (nbrs == 2 && shadow_cells[r][c]);
                    total += nxt[r][c];
                end
            end
            shadow_cells = nxt;
            shadow_live  = total;
            shadow_gen   = shadow_gen + 1'b1;
        end
        res.pop = shadow_live[POP_W-1:0];
        res.gen = shadow_gen;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        mismatches++;
    endtask

    // Presents one transaction after a random gap and waits for it to be taken.
    task automatic send_item(input logic [1:0] op, input logic [4:0] row, input logic [5:0] col,
                             input logic alive, input logic fixed, input life_result_t fixed_res);
        int unsigned  gap;
        life_result_t pred;

        gap = quiet_in ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 39) == 0)
            quiet_in = !quiet_in;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, alive, col, row};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        pred = life_predict(op, row, col, alive);
        results_due.push_back(fixed ? fixed_res : pred);
        items_sent++;
    endtask

    task automatic send_checked(input logic [1:0] op, input logic [4:0] row,
                                input logic [5:0] col, input logic alive);
        send_item(op, row, col, alive, 1'b0, '0);
    endtask

    // Result side: random back-pressure and the field-by-field check.
    initial
    begin : result_sink
        int unsigned  stall;
        life_result_t want;

        @(posedge rst_n);
        forever
        begin
            stall = quiet_out ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 39) == 0)
                quiet_out = !quiet_out;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            if (results_due.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", 0, m_tdata);
            end
            else
            begin
                want = results_due.pop_front();
                if (m_tdata[0] !== want.cell_bit)
                    report_mismatch("cell_value", 32'(want.cell_bit), 32'(m_tdata[0]));
                if (m_tdata[10:1] !== want.pop)
                    report_mismatch("population", 32'(want.pop), 32'(m_tdata[10:1]));
                if (m_tdata[26:11] !== want.gen)
                    report_mismatch("generation", 32'(want.gen), 32'(m_tdata[26:11]));
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Reset, directed table, random episodes, drain.
    initial
    begin : stimulus
        int unsigned r0;
        int unsigned c0;
        int unsigned h;
        int unsigned w;
        int unsigned n;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        mismatches  = 0;
        items_sent  = 0;
        quiet_in    = 1'b0;
        quiet_out   = 1'b0;
        shadow_live = 0;
        shadow_gen  = '0;
        foreach (shadow_cells[r, c])
            shadow_cells[r][c] = 1'b0;

        // Empty-grid reads, no-op and step, out-of-range accesses, then a vertical blinker
        // across the wrapped corner that turns horizontal and back.
        dir_table = '{
            '{OP_READ,   5'd0,  6'd0,  1'b0, 1'b1, '{1'b0, 10'd0, 16'd0}},
            '{OP_READ,   5'd20, 6'd39, 1'b1, 1'b1, '{1'b0, 10'd0, 16'd0}},
            '{OP_UNUSED, 5'd31, 6'd63, 1'b1, 1'b1, '{1'b0, 10'd0, 16'd0}},
            '{OP_STEP,   5'd31, 6'd63, 1'b1, 1'b1, '{1'b0, 10'd0, 16'd1}},
            '{OP_WRITE,  5'd31, 6'd63, 1'b1, 1'b1, '{1'b0, 10'd0, 16'd1}},
            '{OP_WRITE,  5'd20, 6'd40, 1'b1, 1'b1, '{1'b0, 10'd0, 16'd1}},
            '{OP_WRITE,  5'd21, 6'd0,  1'b1, 1'b1, '{1'b0, 10'd0, 16'd1}},
            '{OP_READ,   5'd21, 6'd39, 1'b1, 1'b1, '{1'b0, 10'd0, 16'd1}},
            '{OP_WRITE,  5'd20, 6'd39, 1'b1, 1'b1, '{1'b0, 10'd1, 16'd1}},
            '{OP_WRITE,  5'd0,  6'd39, 1'b1, 1'b0, '0},
            '{OP_WRITE,  5'd1,  6'd39, 1'b1, 1'b0, '0},
            '{OP_WRITE,  5'd1,  6'd39, 1'b1, 1'b0, '0},
            '{OP_WRITE,  5'd5,  6'd5,  1'b0, 1'b0, '0},
            '{OP_READ,   5'd20, 6'd39, 1'b0, 1'b0, '0},
            '{OP_STEP,   5'd0,  6'd0,  1'b0, 1'b0, '0},
            '{OP_READ,   5'd0,  6'd38, 1'b0, 1'b0, '0},
            '{OP_READ,   5'd0,  6'd0,  1'b1, 1'b0, '0},
            '{OP_READ,   5'd20, 6'd39, 1'b0, 1'b0, '0},
            '{OP_STEP,   5'd17, 6'd42, 1'b1, 1'b0, '0},
            '{OP_WRITE,  5'd0,  6'd39, 1'b0, 1'b0, '0},
            '{OP_WRITE,  5'd10, 6'd20, 1'b1, 1'b0, '0},
            '{OP_READ,   5'd10, 6'd20, 1'b1, 1'b0, '0},
            '{OP_UNUSED, 5'd0,  6'd0,  1'b0, 1'b0, '0},
            '{OP_STEP,   5'd0,  6'd0,  1'b0, 1'b0, '0},
            '{OP_READ,   5'd31, 6'd0,  1'b0, 1'b0, '0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_table[i].op, dir_table[i].row, dir_table[i].col,
                      dir_table[i].alive, dir_table[i].fixed, dir_table[i].res);

        // Random part: mostly seeded patches that are evolved and probed, some noise.
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                r0 = $urandom_range(0, ROWS - 1);
                c0 = $urandom_range(0, COLS - 1);
                h  = $urandom_range(3, 8);
                w  = $urandom_range(3, 8);
                n  = $urandom_range(4, 14);
                repeat (n)
                    send_checked(OP_WRITE, 5'((r0 + $urandom_range(0, h - 1)) % ROWS),
                                 6'((c0 + $urandom_range(0, w - 1)) % COLS),
                                 $urandom_range(0, 5) != 0);
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    send_checked(OP_STEP, 5'($urandom_range(0, 31)),
                                 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, 4))
                        send_checked(OP_READ, 5'((r0 + $urandom_range(0, h + 1)) % ROWS),
                                     6'((c0 + $urandom_range(0, w + 1)) % COLS),
                                     1'($urandom_range(0, 1)));
                end
            end
            else
            begin
                repeat ($urandom_range(3, 8))
                    send_checked(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                                 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            end
        end

        // Drain: wait for every outstanding result, then let the block settle before the final check.
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch("results never delivered", 0, results_due.size());

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
